[src/assert_macros.svh]
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, suspended while reset is high
`define FRR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// clocked property, also checked during reset
`define FRR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

[src/frr90_pkg.sv]
// ----------------------------------------------------------------------------
// frr90_pkg
// Types, constants and helper functions of the region rotation unit.
// ----------------------------------------------------------------------------
package frr90_pkg;

  localparam int FRAME_BYTES_DEF = 32768;
  localparam int COORD_W         = 10;
  localparam int SUM_W           = 21;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 9;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_ROTATE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REGION_X = 3'd0,
    CFG_REGION_Y = 3'd1,
    CFG_REGION_W = 3'd2,
    CFG_REGION_H = 3'd3,
    CFG_ROW_BYTES = 3'd4,
    CFG_PIXEL_FORMAT = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_READ,
    S_WB,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PT_A,
    PT_B,
    PT_C,
    PT_D
  } pt_t;

  typedef struct packed {
    logic [2:0] bitpos;
    logic       oor;
  } loc_t;

  // corner visited at each of the eight accesses of one rotation step
  function automatic pt_t rot_point(logic dir, logic [2:0] step);
    pt_t pt;
    case (step)
      3'd0, 3'd2: pt = PT_A;
      3'd1, 3'd4: pt = dir ? PT_B : PT_D;
      3'd3, 3'd6: pt = PT_C;
      3'd5, 3'd7: pt = dir ? PT_D : PT_B;
      default:    pt = PT_A;
    endcase
    return pt;
  endfunction

  function automatic logic rot_is_set(logic [2:0] step);
    return step inside {3'd2, 3'd4, 3'd6, 3'd7};
  endfunction

endpackage

[src/frr90_item_if.sv]
// ----------------------------------------------------------------------------
// frr90_item_if
// Input channel of the region rotation unit: one command per beat.
// ----------------------------------------------------------------------------
interface frr90_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] pixel_x;
  logic [7:0] pixel_y;
  logic [7:0] pixel_value;
  logic       direction;

  modport source (
    output valid, operation, pixel_x, pixel_y, pixel_value, direction,
    input  ready
  );
  modport sink (
    input  valid, operation, pixel_x, pixel_y, pixel_value, direction,
    output ready
  );
endinterface

[src/frr90_result_if.sv]
// ----------------------------------------------------------------------------
// frr90_result_if
// Output channel of the region rotation unit: one result per beat.
// ----------------------------------------------------------------------------
interface frr90_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  logic       out_of_range;

  modport source (output valid, read_value, out_of_range, input ready);
  modport sink   (input valid, read_value, out_of_range, output ready);
endinterface

[src/frr90_mem.sv]
// ----------------------------------------------------------------------------
// frr90_mem
// Frame memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module frr90_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/frr90_addr.sv]
// ----------------------------------------------------------------------------
// frr90_addr
// Address unit: maps a pixel coordinate to a byte address, bit and range flag.
// ----------------------------------------------------------------------------
module frr90_addr
  import frr90_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int AW          = 15
) (
  input  coord_t        x,
  input  coord_t        y,
  input  logic [8:0]    row_bytes,
  input  logic          packed_fmt,
  output logic [AW-1:0] addr,
  output loc_t          loc
);

  logic signed [COORD_W-1:0]   col;
  logic signed [2*COORD_W-1:0] prod;
  logic signed [SUM_W-1:0]     sum;

  always_comb begin
    col  = packed_fmt ? (x >>> 3) : x;
    prod = y * $signed({1'b0, row_bytes});
    sum  = SUM_W'(prod) + SUM_W'(col);
    addr = sum[AW-1:0];
    loc.bitpos = packed_fmt ? x[2:0] : 3'd0;
    loc.oor    = sum[SUM_W-1] || (sum >= $signed(SUM_W'(FRAME_BYTES)));
  end

endmodule

[src/framebuffer_region_rotate_90_unit.sv]
// ----------------------------------------------------------------------------
// framebuffer_region_rotate_90_unit
// Frame memory with pixel write, pixel read and in-place 90 degree rotation
// of a square region, driven by a small access sequencer.
// ----------------------------------------------------------------------------
// One item is in work at a time. Every pixel access goes through the shared
// address unit and the single frame memory port in the address, read and
// write back states. A pixel write or read makes one access and an unused
// operation none. A rotation with q = min(w,h)/2 makes eight accesses for
// each of q*(q-1) steps. The result sits in an output register, so the next
// item is taken while it waits.
module framebuffer_region_rotate_90_unit
  import frr90_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  frr90_item_if.sink            item,
  frr90_result_if.source        result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(FRAME_BYTES);

  // configuration
  logic [7:0] region_x, region_y, region_w, region_h;
  logic [8:0] row_bytes;
  logic       pixel_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_x     <= 8'd0;
      region_y     <= 8'd0;
      region_w     <= 8'd144;
      region_h     <= 8'd144;
      row_bytes    <= 9'd144;
      pixel_format <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REGION_X:     region_x     <= cfg_data[7:0];
        CFG_REGION_Y:     region_y     <= cfg_data[7:0];
        CFG_REGION_W:     region_w     <= cfg_data[7:0];
        CFG_REGION_H:     region_h     <= cfg_data[7:0];
        CFG_ROW_BYTES:    row_bytes    <= cfg_data;
        CFG_PIXEL_FORMAT: pixel_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // region geometry
  logic [7:0] xc, yc;
  logic [6:0] q;
  always_comb begin
    xc = region_x + {1'b0, region_w[7:1]};
    yc = region_y + {1'b0, region_h[7:1]};
    q  = (region_h < region_w) ? region_h[7:1] : region_w[7:1];
  end

  // sequencer state and item registers
  state_t      state, state_next;
  op_t         op;
  logic        dir;
  logic [7:0]  px, py, wval;
  logic [6:0]  c1, c2;
  logic [2:0]  step;
  logic [7:0]  held, tmp, rd_val;
  logic        fault;
  logic [AW-1:0] addr_r;
  loc_t        loc_r;
  logic        res_valid;
  logic [7:0]  res_value;
  logic        res_oor;

  logic accept, last_step, last_c2, last_c1, rot_empty;
  logic out_free;

  assign accept    = item.valid && item.ready;
  assign rot_empty = (q < 7'd2);
  assign last_step = (step == 3'd7);
  assign last_c2   = (c2 == q - 7'd1);
  assign last_c1   = (c1 == q - 7'd1);
  assign out_free  = !res_valid || result.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_t'(item.operation))
            OP_WRITE, OP_READ: state_next = S_ADDR;
            OP_ROTATE:         state_next = rot_empty ? S_DONE : S_ADDR;
            default:           state_next = S_DONE;
          endcase
        end
      end
      S_ADDR: state_next = S_READ;
      S_READ: state_next = S_WB;
      S_WB: begin
        if (op != OP_ROTATE) begin
          state_next = S_DONE;
        end else if (last_step && last_c2 && last_c1) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ADDR;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // coordinate of the current access
  coord_t cx, cy, xs, ys, c1s, c2s;
  logic   is_set;
  always_comb begin
    xs  = coord_t'(xc);
    ys  = coord_t'(yc);
    c1s = coord_t'(c1);
    c2s = coord_t'(c2);
    cx  = coord_t'(px);
    cy  = coord_t'(py);
    if (op == OP_ROTATE) begin
      case (rot_point(dir, step))
        PT_A: begin cx = xs + c2s; cy = ys + c1s; end
        PT_B: begin cx = xs + c1s; cy = ys - c2s; end
        PT_C: begin cx = xs - c2s; cy = ys - c1s; end
        PT_D: begin cx = xs - c1s; cy = ys + c2s; end
        default: ;
      endcase
    end
    is_set = (op == OP_ROTATE) ? rot_is_set(step) : (op == OP_WRITE);
  end

  logic [AW-1:0] addr_c;
  loc_t          loc_c;

  frr90_addr #(
    .FRAME_BYTES(FRAME_BYTES),
    .AW         (AW)
  ) u_addr (
    .x         (cx),
    .y         (cy),
    .row_bytes (row_bytes),
    .packed_fmt(pixel_format),
    .addr      (addr_c),
    .loc       (loc_c)
  );

  // memory and read-modify-write data
  logic       mem_we;
  logic [7:0] mem_rdata, mem_wdata, get_val, set_val, mask;

  always_comb begin
    mask    = 8'd1 << loc_r.bitpos;
    get_val = 8'd0;
    if (!loc_r.oor) begin
      get_val = pixel_format ? {7'd0, mem_rdata[loc_r.bitpos]} : mem_rdata;
    end
    if (op == OP_ROTATE) begin
      set_val = last_step ? held : tmp;
    end else begin
      set_val = wval;
    end
    if (pixel_format) begin
      mem_wdata = set_val[0] ? (mem_rdata | mask) : (mem_rdata & ~mask);
    end else begin
      mem_wdata = set_val;
    end
  end

  // outputs of the sequencer
  always_comb begin
    item.ready = (state == S_IDLE);
    mem_we     = (state == S_WB) && is_set && !loc_r.oor;
  end

  frr90_mem #(
    .DEPTH(FRAME_BYTES),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .addr (addr_r),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= op_t'(item.operation);
      dir    <= item.direction;
      px     <= item.pixel_x;
      py     <= item.pixel_y;
      wval   <= item.pixel_value;
      c1     <= 7'd0;
      c2     <= 7'd1;
      step   <= 3'd0;
      fault  <= 1'b0;
      rd_val <= 8'd0;
    end
    if (state == S_ADDR) begin
      addr_r <= addr_c;
      loc_r  <= loc_c;
      fault  <= fault | loc_c.oor;
    end
    if (state == S_WB) begin
      if (op == OP_READ) begin
        rd_val <= get_val;
      end
      if (op == OP_ROTATE) begin
        if (step == 3'd0) begin
          held <= get_val;
        end else if (!is_set) begin
          tmp <= get_val;
        end
        step <= step + 3'd1;
        if (last_step) begin
          if (last_c2) begin
            c2 <= 7'd1;
            c1 <= c1 + 7'd1;
          end else begin
            c2 <= c2 + 7'd1;
          end
        end
      end
    end
    if (state == S_DONE && out_free) begin
      res_value <= rd_val;
      res_oor   <= fault;
    end
  end

  assign result.valid        = res_valid;
  assign result.read_value   = res_value;
  assign result.out_of_range = res_oor;

endmodule

[src/frr90_check.sv]
// ----------------------------------------------------------------------------
// frr90_check
// Port-level checks of the region rotation unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frr90_check (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_value,
  input logic       out_of_range
);

  // result beat holds until taken
  `FRR_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  // stalled result payload is stable
  `FRR_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(read_value) && $stable(out_of_range))
  // one item at a time: busy right after an accepted beat
  `FRR_ASSERT(a_busy_after_accept, clk, rst, in_valid && in_ready |=> !in_ready)
  // reset leaves no result pending
  `FRR_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid)

endmodule

bind framebuffer_region_rotate_90_unit frr90_check u_check (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (item.valid),
  .in_ready    (item.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .read_value  (result.read_value),
  .out_of_range(result.out_of_range)
);

[tb/tb_framebuffer_region_rotate_90_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framebuffer_region_rotate_90_unit
// Self-checking bench for the frame memory rotator. Pixel writes, reads and
// region rotations go in through the command channel in random bursts, and
// a shadow copy of the frame memory works out the read value and range flag
// of every command. Results are taken under a changing stall pattern and
// checked in order. Each region setting first fills the bytes that its
// rotation touches, so no command ever reads a byte that was never written.
// ----------------------------------------------------------------------------
module tb_framebuffer_region_rotate_90_unit;
  import frr90_pkg::*;

  localparam int FRAME_BYTES = FRAME_BYTES_DEF;
  localparam int CMD_TARGET  = 1750;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    op_t        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] value;
    logic       dir;
  } pixel_cmd_t;

  typedef struct {
    logic [7:0] read_value;
    logic       out_of_range;
  } pixel_resp_t;

  typedef struct packed {
    logic [7:0] x;
    logic [7:0] y;
  } pixel_pos_t;

  logic clk;
  logic rst = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_REGION_X;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  frr90_item_if   item_ch ();
  frr90_result_if result_ch ();

  framebuffer_region_rotate_90_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (result_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // shadow of the register file
  bit [7:0] cfg_region_x = 8'd0;
  bit [7:0] cfg_region_y = 8'd0;
  bit [7:0] cfg_region_w = 8'd144;
  bit [7:0] cfg_region_h = 8'd144;
  bit [8:0] cfg_row_bytes = 9'd144;
  bit       cfg_packed = 1'b0;

  // shadow frame memory and which bytes hold known data
  bit [7:0] frame_model [FRAME_BYTES];
  bit       frame_defined [FRAME_BYTES];
  bit       range_fault;

  pixel_cmd_t  cmd_queue [$];
  pixel_resp_t expected_resp [$];
  pixel_pos_t  footprint_pts [$];
  pixel_pos_t  written_pts [$];

  int cmds_sent, rotations_sent, settings_used;
  int results_seen, flagged_seen, mismatch_count;
  int burst_left, gap_left, stall_mode, stall_left;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    item_ch.valid       = 1'b0;
    item_ch.operation   = OP_NONE;
    item_ch.pixel_x     = '0;
    item_ch.pixel_y     = '0;
    item_ch.pixel_value = '0;
    item_ch.direction   = 1'b0;
    result_ch.ready     = 1'b0;
  end

  function automatic bit in_frame(int addr);
    return addr >= 0 && addr < FRAME_BYTES;
  endfunction

  function automatic int pixel_addr(int x, int y, bit packed_fmt, output int bpos);
    int col;
    if (packed_fmt) begin
      col  = ((x + 1024) >> 3) - 128;
      bpos = (x + 1024) & 7;
    end else begin
      col  = x;
      bpos = 0;
    end
    return y * int'(cfg_row_bytes) + col;
  endfunction

  function automatic void region_centre(output int xc, output int yc, output int q);
    bit [7:0] xc8, yc8, side;
    xc8  = cfg_region_x + (cfg_region_w >> 1);
    yc8  = cfg_region_y + (cfg_region_h >> 1);
    side = (cfg_region_h < cfg_region_w) ? cfg_region_h : cfg_region_w;
    xc = xc8;
    yc = yc8;
    q  = side >> 1;
  endfunction

  function automatic bit [7:0] pixel_load(int x, int y);
    int addr, bpos;
    addr = pixel_addr(x, y, cfg_packed, bpos);
    if (!in_frame(addr)) begin
      range_fault = 1'b1;
      return 8'd0;
    end
    if (cfg_packed) return {7'd0, frame_model[addr][bpos]};
    return frame_model[addr];
  endfunction

  function automatic void pixel_store(int x, int y, bit [7:0] v);
    int addr, bpos;
    addr = pixel_addr(x, y, cfg_packed, bpos);
    if (!in_frame(addr)) begin
      range_fault = 1'b1;
      return;
    end
    if (cfg_packed) frame_model[addr][bpos] = v[0];
    else frame_model[addr] = v;
  endfunction

  function automatic void rotate_shadow(bit dir);
    int xc, yc, q;
    bit [7:0] held;
    region_centre(xc, yc, q);
    for (int c1 = 0; c1 < q; c1++) begin
      for (int c2 = 1; c2 < q; c2++) begin
        held = pixel_load(xc + c2, yc + c1);
        if (dir) begin
          pixel_store(xc + c2, yc + c1, pixel_load(xc + c1, yc - c2));
          pixel_store(xc + c1, yc - c2, pixel_load(xc - c2, yc - c1));
          pixel_store(xc - c2, yc - c1, pixel_load(xc - c1, yc + c2));
          pixel_store(xc - c1, yc + c2, held);
        end else begin
          pixel_store(xc + c2, yc + c1, pixel_load(xc - c1, yc + c2));
          pixel_store(xc - c1, yc + c2, pixel_load(xc - c2, yc - c1));
          pixel_store(xc - c2, yc - c1, pixel_load(xc + c1, yc - c2));
          pixel_store(xc + c1, yc - c2, held);
        end
      end
    end
  endfunction

  function automatic pixel_resp_t frame_response(pixel_cmd_t c);
    pixel_resp_t r;
    r.read_value = 8'd0;
    range_fault = 1'b0;
    case (c.op)
      OP_WRITE:  pixel_store(c.x, c.y, c.value);
      OP_READ:   r.read_value = pixel_load(c.x, c.y);
      OP_ROTATE: rotate_shadow(c.dir);
      default: ;
    endcase
    r.out_of_range = range_fault;
    return r;
  endfunction

  // command side: bursts of random length with random gaps
  always @(posedge clk) begin
    bit took;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else begin
      took = item_ch.valid && item_ch.ready;
      if (took) begin
        expected_resp.push_back(frame_response(cmd_queue.pop_front()));
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!item_ch.valid || took) begin
        if (gap_left > 0) begin
          item_ch.valid <= 1'b0;
          gap_left--;
        end else if (cmd_queue.size() != 0) begin
          item_ch.valid       <= 1'b1;
          item_ch.operation   <= cmd_queue[0].op;
          item_ch.pixel_x     <= cmd_queue[0].x;
          item_ch.pixel_y     <= cmd_queue[0].y;
          item_ch.pixel_value <= cmd_queue[0].value;
          item_ch.direction   <= cmd_queue[0].dir;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side: stall mode switches between open, random and mostly held
  always @(posedge clk) begin
    pixel_resp_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_resp.size() == 0) begin
          $error("unexpected result beat: read_value %0d, out_of_range %0b",
                 result_ch.read_value, result_ch.out_of_range);
          mismatch_count++;
        end else begin
          want = expected_resp.pop_front();
          results_seen++;
          if (want.out_of_range) flagged_seen++;
          if (result_ch.read_value !== want.read_value) begin
            $error("read_value mismatch: expected %0d, actual %0d",
                   want.read_value, result_ch.read_value);
            mismatch_count++;
          end
          if (result_ch.out_of_range !== want.out_of_range) begin
            $error("out_of_range mismatch: expected %0b, actual %0b",
                   want.out_of_range, result_ch.out_of_range);
            mismatch_count++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= $urandom_range(0, 1);
        default: result_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_REGION_X:     cfg_region_x  = value;
      CFG_REGION_Y:     cfg_region_y  = value;
      CFG_REGION_W:     cfg_region_w  = value;
      CFG_REGION_H:     cfg_region_h  = value;
      CFG_ROW_BYTES:    cfg_row_bytes = value;
      CFG_PIXEL_FORMAT: cfg_packed    = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // byte format first; the fill writes need byte addressing
  task automatic apply_config(bit [7:0] rx, bit [7:0] ry, bit [7:0] rw, bit [7:0] rh,
                              bit [8:0] rb);
    write_reg(CFG_PIXEL_FORMAT, 0);
    write_reg(CFG_REGION_X, rx);
    write_reg(CFG_REGION_Y, ry);
    write_reg(CFG_REGION_W, rw);
    write_reg(CFG_REGION_H, rh);
    write_reg(CFG_ROW_BYTES, rb);
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() != 0 || expected_resp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_cmd(op_t op, bit [7:0] x, bit [7:0] y, bit [7:0] value, bit dir);
    pixel_cmd_t c;
    pixel_pos_t p;
    int addr, bpos;
    c.op = op;
    c.x = x;
    c.y = y;
    c.value = value;
    c.dir = dir;
    cmd_queue.push_back(c);
    cmds_sent++;
    if (op == OP_ROTATE) rotations_sent++;
    if (op == OP_WRITE) begin
      p.x = x;
      p.y = y;
      written_pts.push_back(p);
      if (!cfg_packed) begin
        addr = pixel_addr(x, y, 1'b0, bpos);
        if (in_frame(addr)) frame_defined[addr] = 1'b1;
      end
    end
  endtask

  // byte-mode write coordinates that land on a given address
  function automatic bit writer_for(int addr, output bit [7:0] wx, output bit [7:0] wy);
    int row;
    if (cfg_row_bytes == 0) begin
      wx = addr;
      wy = $urandom_range(0, 255);
      return addr <= 255;
    end
    row = addr / int'(cfg_row_bytes);
    if (row > 255) row = 255;
    wx = addr - row * int'(cfg_row_bytes);
    wy = row;
    return addr - row * int'(cfg_row_bytes) <= 255;
  endfunction

  // walks the rotation footprint; with fill set, writes every unknown byte
  task automatic scan_footprint(bit packed_fmt, bit fill, output bit ok);
    int xc, yc, q, addr, bpos;
    int px [4];
    int py [4];
    bit [7:0] wx, wy;
    pixel_pos_t p;
    region_centre(xc, yc, q);
    ok = 1'b1;
    if (fill) footprint_pts.delete();
    for (int c1 = 0; c1 < q; c1++) begin
      for (int c2 = 1; c2 < q; c2++) begin
        px = '{xc + c2, xc + c1, xc - c2, xc - c1};
        py = '{yc + c1, yc - c2, yc - c1, yc + c2};
        for (int k = 0; k < 4; k++) begin
          addr = pixel_addr(px[k], py[k], packed_fmt, bpos);
          if (fill && px[k] >= 0 && px[k] <= 255 && py[k] >= 0 && py[k] <= 255) begin
            p.x = px[k];
            p.y = py[k];
            footprint_pts.push_back(p);
          end
          if (in_frame(addr) && !frame_defined[addr]) begin
            if (!writer_for(addr, wx, wy)) ok = 1'b0;
            else if (fill) push_cmd(OP_WRITE, wx, wy, $urandom_range(0, 255),
                                    $urandom_range(0, 1));
          end
        end
      end
    end
  endtask

  // a pixel whose byte holds known data, or lies outside the memory
  function automatic bit pick_target(bit packed_fmt, output bit [7:0] x, output bit [7:0] y);
    int sel, addr, bpos;
    pixel_pos_t p;
    for (int tries = 0; tries < 16; tries++) begin
      sel = $urandom_range(0, 3);
      if (sel < 2 && footprint_pts.size() != 0) begin
        p = footprint_pts[$urandom_range(0, footprint_pts.size() - 1)];
        x = p.x;
        y = p.y;
      end else if (sel == 2 && written_pts.size() != 0) begin
        p = written_pts[$urandom_range(0, written_pts.size() - 1)];
        x = p.x;
        y = p.y;
      end else begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end
      addr = pixel_addr(x, y, packed_fmt, bpos);
      if (!in_frame(addr) || frame_defined[addr]) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_random_cmd();
    int sel;
    bit [7:0] x, y;
    pixel_pos_t p;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      push_cmd(OP_ROTATE, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 1));
    end else if (sel < 12) begin
      push_cmd(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 1));
    end else if (sel < 55 && !cfg_packed) begin
      if (footprint_pts.size() != 0 && $urandom_range(0, 1)) begin
        p = footprint_pts[$urandom_range(0, footprint_pts.size() - 1)];
        x = p.x;
        y = p.y;
      end else begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end
      push_cmd(OP_WRITE, x, y, $urandom_range(0, 255), $urandom_range(0, 1));
    end else if (pick_target(cfg_packed, x, y)) begin
      push_cmd(sel < 55 ? OP_WRITE : OP_READ, x, y, $urandom_range(0, 255),
               $urandom_range(0, 1));
    end else begin
      push_cmd(OP_NONE, x, y, $urandom_range(0, 255), $urandom_range(0, 1));
    end
  endtask

  task automatic run_setting(bit packed_fmt, int n_cmds);
    bit ok;
    written_pts.delete();
    scan_footprint(packed_fmt, 1'b1, ok);
    if (packed_fmt) begin
      wait_idle();
      write_reg(CFG_PIXEL_FORMAT, 1);
    end
    push_cmd(OP_ROTATE, 8'h00, 8'hff, 8'h00, 1'b1);
    repeat (n_cmds) push_random_cmd();
    push_cmd(OP_ROTATE, 8'hff, 8'h00, 8'hff, 1'b0);
    wait_idle();
    settings_used++;
  endtask

  initial begin
    bit ok, fmt;
    bit [7:0] rx, ry, rw, rh, sm, bg;
    bit [8:0] rb;
    int qq, pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: corners of the field ranges, drops past the end
    push_cmd(OP_WRITE, 8'd0, 8'd0, 8'h00, 1'b0);
    push_cmd(OP_WRITE, 8'd255, 8'd0, 8'hff, 1'b1);
    push_cmd(OP_WRITE, 8'd17, 8'd3, 8'h5a, 1'b0);
    push_cmd(OP_READ, 8'd0, 8'd0, 8'hff, 1'b1);
    push_cmd(OP_READ, 8'd255, 8'd0, 8'h00, 1'b0);
    push_cmd(OP_READ, 8'd17, 8'd3, 8'ha5, 1'b1);
    push_cmd(OP_WRITE, 8'd0, 8'd255, 8'hc3, 1'b0);
    push_cmd(OP_READ, 8'd255, 8'd255, 8'd0, 1'b0);
    push_cmd(OP_NONE, 8'd255, 8'd255, 8'hff, 1'b1);
    wait_idle();

    apply_config(8'd0, 8'd0, 8'd5, 8'd4, 9'd16);
    run_setting(1'b0, 1);
    // centre column 0: negative columns in packed format
    apply_config(8'd254, 8'd3, 8'd4, 8'd6, 9'd40);
    run_setting(1'b1, 1);
    // empty regions
    apply_config(8'd255, 8'd255, 8'd255, 8'd0, 9'd256);
    run_setting(1'b0, 1);
    apply_config(8'd10, 8'd10, 8'd3, 8'd255, 9'd1);
    run_setting(1'b1, 1);
    // zero row width: every row aliases the first
    apply_config(8'd100, 8'd50, 8'd6, 8'd6, 9'd0);
    run_setting(1'b0, 1);
    // centre row 0: rotation reaches below the memory
    apply_config(8'd20, 8'd254, 8'd8, 8'd5, 9'd30);
    run_setting(1'b0, 1);

    while (cmds_sent < CMD_TARGET) begin
      do begin
        qq = $urandom_range(0, 7);
        sm = 2 * qq + $urandom_range(0, 1);
        if ($urandom_range(0, 1)) bg = $urandom_range(sm, 255);
        else bg = sm + $urandom_range(0, 3);
        if ($urandom_range(0, 1)) begin
          rw = sm;
          rh = bg;
        end else begin
          rw = bg;
          rh = sm;
        end
        rx = $urandom_range(0, 255);
        ry = $urandom_range(0, 255);
        pick = $urandom_range(0, 9);
        if (pick == 0) rb = $urandom_range(0, 8);
        else if (pick < 6) rb = $urandom_range(9, 200);
        else rb = $urandom_range(201, 256);
        fmt = $urandom_range(0, 1);
        apply_config(rx, ry, rw, rh, rb);
        scan_footprint(fmt, 1'b0, ok);
      end while (!ok);
      run_setting(fmt, $urandom_range(30, 70));
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("covered %0d commands, %0d of them rotations, over %0d region settings",
             cmds_sent, rotations_sent, settings_used);
    $display("checked %0d results, %0d flagged out of range, %0d mismatches",
             results_seen, flagged_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
